[hdl/srld_pkg.sv]
// Shared types, codes and helpers for the serial RGB LED waveform driver.
package srld_pkg;

    localparam int BITS_PER_LED = 24;
    localparam int TICK_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Input modes
    localparam logic [1:0] MODE_WRITE_ONE = 2'd0;
    localparam logic [1:0] MODE_WRITE_ALL = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_TICK = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_NOTHING = 2'd2;

    // Waveform phases
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH = 3'd6;

    // Configuration reset values
    localparam logic [TICK_W-1:0] RST_ONE_HIGH = 15'd64;
    localparam logic [TICK_W-1:0] RST_ONE_LOW = 15'd36;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 15'd32;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW = 15'd68;
    localparam logic [TICK_W-1:0] RST_LATCH = 15'd4000;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic       pin_level;
        logic       busy_res;
        logic [1:0] status;
        logic       frame_done;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic cfg_we;
        logic sweep_wr;
        logic fetch_rd;
        logic fetch_ld;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_start;
        logic sweep_done;
        logic fetch_start;
    } dp_status_t;

    // Stored color is red, green, blue; reorder for transmission.
    function automatic logic [BITS_PER_LED-1:0] order_bits(
        input logic [BITS_PER_LED-1:0] color,
        input logic                     rgb_order
    );
        logic [BITS_PER_LED-1:0] res;
        if (rgb_order) begin
            res = color;
        end else begin
            res = {color[15:8], color[23:16], color[7:0]};
        end
        return res;
    endfunction

endpackage

[hdl/srld_ctrl.sv]
// Control state machine and result handshake of the LED waveform driver.
module srld_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  srld_pkg::dp_status_t  st,
    output srld_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       idle;
    logic       accept;

    assign idle = (state_reg == S_IDLE);
    assign s_ready = idle && (!m_valid_reg || m_ready);
    assign accept = s_valid && s_ready;
    assign cfg_ready = idle;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.accept = accept;
        cmd.cfg_we = cfg_valid && idle;
        cmd.sweep_wr = (state_reg == S_SWEEP);
        cmd.fetch_rd = (state_reg == S_FETCH);
        cmd.fetch_ld = (state_reg == S_LOAD);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP: begin
                if (st.sweep_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept && st.sweep_start) begin
                    state_next = S_SWEEP;
                end else if (accept && st.fetch_start) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_LOAD;
            S_LOAD:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Reset starts with a clearing sweep of the frame store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/srld_datapath.sv]
// Frame store, configuration registers and waveform generator datapath.
module srld_datapath #(
    parameter int MAX_LEDS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  srld_pkg::ctrl_cmd_t                 cmd,
    output srld_pkg::dp_status_t                st,
    input  srld_pkg::in_item_t                  s_data,
    input  logic [srld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srld_pkg::CFG_DATA_W-1:0]     cfg_data,
    output srld_pkg::out_item_t                 m_data
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = ($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9;
    localparam int BW = srld_pkg::BITS_PER_LED;
    localparam int TW = srld_pkg::TICK_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);
    localparam logic [4:0] LAST_BIT = 5'(BW - 1);

    // Configuration registers
    logic          color_order_reg;
    logic [7:0]    led_count_reg;
    logic [TW-1:0] one_high_reg, one_low_reg, zero_high_reg, zero_low_reg, latch_reg;

    // Frame store
    logic [BW-1:0] mem [MAX_LEDS];
    logic [BW-1:0] rd_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] wr_data;
    logic          single_wr;

    // Sweep for clearing and write-all
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0] sweep_last_reg, sweep_last_next;
    logic [BW-1:0] sweep_data_reg, sweep_data_next;

    // Waveform state
    logic          pending_reg, pending_next;
    logic          sending_reg, sending_next;
    logic [7:0]    led_pos_reg, led_pos_next;
    logic [4:0]    bit_pos_reg, bit_pos_next;
    logic [1:0]    phase_reg, phase_next;
    logic [TW-1:0] tick_reg, tick_next;
    logic [BW-1:0] shifter_reg, shifter_next;

    srld_pkg::out_item_t res_reg, res_next;

    logic [CW-1:0] count_ext, eff_n, n_minus1, idx_ext, pos_ext, next_pos;
    logic [BW-1:0] color;
    logic          cur_one;
    logic [TW-1:0] dur;
    logic          reached;

    assign count_ext = CW'(led_count_reg);
    assign eff_n = (count_ext < MAX_CNT) ? count_ext : MAX_CNT;
    assign n_minus1 = eff_n - CW'(1);
    assign idx_ext = CW'(s_data.led_index);
    assign pos_ext = CW'(led_pos_reg);
    assign next_pos = pos_ext + CW'(1);
    assign color = {s_data.red, s_data.green, s_data.blue};
    assign cur_one = shifter_reg[BW-1];

    // Duration of the current part; a zero duration acts as one tick.
    always_comb begin
        case (phase_reg)
            srld_pkg::PH_HIGH: dur = cur_one ? one_high_reg : zero_high_reg;
            srld_pkg::PH_LOW:  dur = cur_one ? one_low_reg : zero_low_reg;
            default:           dur = latch_reg;
        endcase
    end
    assign reached = ({1'b0, tick_reg} + 16'd1) >= {1'b0, dur};

    always_comb begin
        pending_next = pending_reg;
        sending_next = sending_reg;
        led_pos_next = led_pos_reg;
        bit_pos_next = bit_pos_reg;
        phase_next = phase_reg;
        tick_next = tick_reg;
        shifter_next = shifter_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_data_next = sweep_data_reg;
        single_wr = 1'b0;
        st.sweep_start = 1'b0;
        st.fetch_start = 1'b0;
        st.sweep_done = (sweep_addr_reg == sweep_last_reg);
        res_next.pin_level = sending_reg && (phase_reg == srld_pkg::PH_HIGH);
        res_next.status = srld_pkg::STATUS_OK;
        res_next.frame_done = 1'b0;

        if (cmd.sweep_wr) begin
            sweep_addr_next = sweep_addr_reg + AW'(1);
        end
        if (cmd.fetch_ld) begin
            shifter_next = srld_pkg::order_bits(rd_reg, color_order_reg);
        end
        if (cmd.cfg_we && (cfg_index == srld_pkg::CFG_LED_COUNT)) begin
            pending_next = 1'b0;
        end

        if (cmd.accept) begin
            case (s_data.mode)
                srld_pkg::MODE_WRITE_ONE, srld_pkg::MODE_WRITE_ALL: begin
                    if (sending_reg) begin
                        res_next.status = srld_pkg::STATUS_BUSY;
                    end else if (eff_n != '0) begin
                        pending_next = 1'b1;
                        if (s_data.mode == srld_pkg::MODE_WRITE_ALL) begin
                            st.sweep_start = 1'b1;
                            sweep_addr_next = '0;
                            sweep_last_next = n_minus1[AW-1:0];
                            sweep_data_next = color;
                        end else if (idx_ext < eff_n) begin
                            single_wr = 1'b1;
                        end
                    end
                end
                srld_pkg::MODE_START: begin
                    if (sending_reg) begin
                        res_next.status = srld_pkg::STATUS_BUSY;
                    end else if ((eff_n == '0) || !pending_reg) begin
                        res_next.status = srld_pkg::STATUS_NOTHING;
                    end else begin
                        pending_next = 1'b0;
                        sending_next = 1'b1;
                        led_pos_next = '0;
                        bit_pos_next = '0;
                        phase_next = srld_pkg::PH_HIGH;
                        tick_next = '0;
                        st.fetch_start = 1'b1;
                        res_next.pin_level = 1'b1;
                    end
                end
                default: begin
                    if (sending_reg) begin
                        if (!reached) begin
                            tick_next = tick_reg + TW'(1);
                        end else begin
                            tick_next = '0;
                            case (phase_reg)
                                srld_pkg::PH_HIGH: phase_next = srld_pkg::PH_LOW;
                                srld_pkg::PH_LOW: begin
                                    shifter_next = {shifter_reg[BW-2:0], 1'b0};
                                    phase_next = srld_pkg::PH_HIGH;
                                    if (bit_pos_reg == LAST_BIT) begin
                                        bit_pos_next = '0;
                                        if (next_pos >= eff_n) begin
                                            phase_next = srld_pkg::PH_LATCH;
                                        end else begin
                                            led_pos_next = next_pos[7:0];
                                            st.fetch_start = 1'b1;
                                        end
                                    end else begin
                                        bit_pos_next = bit_pos_reg + 5'd1;
                                    end
                                end
                                default: begin
                                    phase_next = srld_pkg::PH_HIGH;
                                    led_pos_next = '0;
                                    bit_pos_next = '0;
                                    sending_next = 1'b0;
                                    res_next.frame_done = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
        res_next.busy_res = sending_next;
    end

    assign wr_en = cmd.sweep_wr || single_wr;
    assign wr_addr = cmd.sweep_wr ? sweep_addr_reg : idx_ext[AW-1:0];
    assign wr_data = cmd.sweep_wr ? sweep_data_reg : color;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.fetch_rd) begin
            rd_reg <= mem[pos_ext[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_order_reg <= 1'b0;
            led_count_reg <= '0;
            one_high_reg <= srld_pkg::RST_ONE_HIGH;
            one_low_reg <= srld_pkg::RST_ONE_LOW;
            zero_high_reg <= srld_pkg::RST_ZERO_HIGH;
            zero_low_reg <= srld_pkg::RST_ZERO_LOW;
            latch_reg <= srld_pkg::RST_LATCH;
        end else if (cmd.cfg_we) begin
            case (cfg_index)
                srld_pkg::CFG_COLOR_ORDER: color_order_reg <= cfg_data[0];
                srld_pkg::CFG_LED_COUNT:   led_count_reg <= cfg_data[7:0];
                srld_pkg::CFG_ONE_HIGH:    one_high_reg <= cfg_data;
                srld_pkg::CFG_ONE_LOW:     one_low_reg <= cfg_data;
                srld_pkg::CFG_ZERO_HIGH:   zero_high_reg <= cfg_data;
                srld_pkg::CFG_ZERO_LOW:    zero_low_reg <= cfg_data;
                srld_pkg::CFG_LATCH:       latch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_ADDR;
            sweep_data_reg <= '0;
            pending_reg <= 1'b0;
            sending_reg <= 1'b0;
            led_pos_reg <= '0;
            bit_pos_reg <= '0;
            phase_reg <= srld_pkg::PH_HIGH;
            tick_reg <= '0;
            shifter_reg <= '0;
        end else begin
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_data_reg <= sweep_data_next;
            pending_reg <= pending_next;
            sending_reg <= sending_next;
            led_pos_reg <= led_pos_next;
            bit_pos_reg <= bit_pos_next;
            phase_reg <= phase_next;
            tick_reg <= tick_next;
            shifter_reg <= shifter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_reg <= res_next;
        end
    end

    assign m_data = res_reg;

endmodule

[hdl/serial_rgb_led_waveform_driver.sv]
// Serial RGB LED waveform driver: top level joining controller and datapath.
// The result of an item is registered and presented in the cycle after its transfer.
// Throughput: one item per cycle while results are taken, except after an accepted write-all
// (held during its sweep) and a start or a next-LED move (held for the S_FETCH, S_LOAD read).
// Reset: synchronous; a sweep of all MAX_LEDS entries clears the store before any transfer.
module serial_rgb_led_waveform_driver #(
    parameter int MAX_LEDS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  srld_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output srld_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srld_pkg::CFG_DATA_W-1:0]     cfg_data
);

    srld_pkg::ctrl_cmd_t  cmd;
    srld_pkg::dp_status_t st;

    srld_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .st        (st),
        .cmd       (cmd)
    );

    srld_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_data    (s_data),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // Never take an item while a result is stuck in the output register.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while result blocked");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after item transfer");

    // End of frame drops busy and holds the line low.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> (!m_data.busy_res && !m_data.pin_level))
        else $error("frame done while still busy");

    // Sweep and fetch never overlap the item or configuration transfer.
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep_wr || cmd.fetch_rd || cmd.fetch_ld) |-> (!s_ready && !cfg_ready))
        else $error("handshake open during internal operation");
`endif

endmodule
